// ===== rtl/stbs_pkg.sv =====
// ============================================================================
// stbs_pkg
// Shared constants and controller/datapath interface types for the sorted
// table binary search block.
// ============================================================================
package stbs_pkg;

    localparam int ADDR_W      = 10;                 // table position width
    localparam int TABLE_DEPTH = 1 << ADDR_W;        // table entries
    localparam int COUNT_W     = ADDR_W + 1;         // holds 0..TABLE_DEPTH and beyond
    localparam int DATA_W      = 32;                 // element width

    localparam int S_TDATA_W   = 48;                 // position + value, byte padded
    localparam int M_TDATA_W   = 16;                 // match position, byte padded

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic wr;       // store element at position
        logic load;     // start search: set bounds, latch target
        logic rd;       // read table at current mid
        logic step;     // compare read data, update bounds or record hit
        logic publish;  // move search result into output register
    } stbs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic active;   // low <= high, a probe remains
        logic equal;    // probed element equals target
    } stbs_stat_t;

endpackage

// ===== rtl/stbs_ctrl.sv =====
// ============================================================================
// stbs_ctrl
// Search sequencer: accepts items, steps probes, hands results to the output.
// ============================================================================
module stbs_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  logic               in_mode,
    output logic               in_ready,
    input  logic               out_ready,
    output logic               out_valid,
    input  stbs_pkg::stbs_stat_t stat,
    output stbs_pkg::stbs_cmd_t  cmd
);
    import stbs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if (in_mode == MODE_SEARCH) begin
                        cmd.load   = 1'b1;
                        state_next = ST_PROBE;
                    end else begin
                        cmd.wr = 1'b1;
                    end
                end
            end
            ST_PROBE: begin
                if (stat.active) begin
                    cmd.rd     = 1'b1;
                    state_next = ST_CMP;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_CMP: begin
                cmd.step   = 1'b1;
                state_next = stat.equal ? ST_DONE : ST_PROBE;
            end
            ST_DONE: begin
                if (!out_valid_reg || out_ready) begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/stbs_dp.sv =====
// ============================================================================
// stbs_dp
// Table memory, search bounds, probe compare and result registers.
// ============================================================================
module stbs_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [stbs_pkg::COUNT_W-1:0]  cfg_wr_data,
    input  logic [stbs_pkg::ADDR_W-1:0]   in_position,
    input  logic [stbs_pkg::DATA_W-1:0]   in_value,
    input  stbs_pkg::stbs_cmd_t           cmd,
    output stbs_pkg::stbs_stat_t          stat,
    output logic                          out_found,
    output logic [stbs_pkg::ADDR_W-1:0]   out_position
);
    import stbs_pkg::*;

    logic [DATA_W-1:0]  mem [TABLE_DEPTH];

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_eff;
    logic [COUNT_W-1:0] lo_reg;        // low bound
    logic [COUNT_W-1:0] hi_reg;        // high bound plus one
    logic [COUNT_W:0]   mid_sum;
    logic [ADDR_W-1:0]  mid;
    logic [ADDR_W-1:0]  mid_reg;
    logic [DATA_W-1:0]  rd_data_reg;
    logic [DATA_W-1:0]  target_reg;
    logic               hit_reg;
    logic [ADDR_W-1:0]  hit_pos_reg;
    logic               found_reg;
    logic [ADDR_W-1:0]  pos_reg;
    logic               greater;

    assign count_eff = (count_reg > COUNT_W'(TABLE_DEPTH)) ? COUNT_W'(TABLE_DEPTH) : count_reg;

    // lo < hi holds whenever a read is issued, so the sum never underflows
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} - (COUNT_W+1)'(1);
    assign mid     = mid_sum[ADDR_W:1];

    assign greater     = $signed(rd_data_reg) > $signed(target_reg);
    assign stat.active = lo_reg < hi_reg;
    assign stat.equal  = rd_data_reg == target_reg;

    assign out_found    = found_reg;
    assign out_position = pos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= COUNT_W'(1);
        end else if (cfg_wr_en) begin
            count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr) begin
            mem[in_position] <= in_value;
        end
        if (cmd.rd) begin
            rd_data_reg <= mem[mid];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            lo_reg      <= '0;
            hi_reg      <= count_eff;
            target_reg  <= in_value;
            hit_reg     <= 1'b0;
            hit_pos_reg <= '0;
        end
        if (cmd.rd) begin
            mid_reg <= mid;
        end
        if (cmd.step) begin
            if (stat.equal) begin
                hit_reg     <= 1'b1;
                hit_pos_reg <= mid_reg;
            end else if (greater) begin
                hi_reg <= {1'b0, mid_reg};
            end else begin
                lo_reg <= {1'b0, mid_reg} + COUNT_W'(1);
            end
        end
        if (cmd.publish) begin
            found_reg <= hit_reg;
            pos_reg   <= hit_pos_reg;
        end
    end

endmodule

// ===== rtl/sorted_table_binary_search.sv =====
// ============================================================================
// sorted_table_binary_search
// Timing: a write transfer is stored as it is accepted. A search steps through
//   probes, each a synchronous table read then a compare, up to 11 probes
//   with 1024 entries; the table's single read port sets this.
// Throughput: one write per cycle while idle; one search at a time, the next
//   transfer accepted once the result is registered.
//   A finished result may wait in the output register meanwhile.
// Reset: aresetn (synchronous, active low) idles the sequencer, drops m_tvalid
//   and sets element_count to 1. Table contents are not cleared.
// ============================================================================
module sorted_table_binary_search (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration: element_count
    input  logic                            cfg_wr_en,
    input  logic [stbs_pkg::COUNT_W-1:0]    cfg_wr_data,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [stbs_pkg::S_TDATA_W-1:0]  s_tdata,  // [9:0] position, [41:10] value, pad
    input  logic                            s_tuser,  // [0] mode: 0 write, 1 search
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [stbs_pkg::M_TDATA_W-1:0]  m_tdata,  // [9:0] match_position, pad
    output logic                            m_tuser   // [0] found
);
    import stbs_pkg::*;

    stbs_cmd_t          cmd;
    stbs_stat_t         stat;
    logic [ADDR_W-1:0]  in_position;
    logic [DATA_W-1:0]  in_value;
    logic [ADDR_W-1:0]  out_position;
    logic               out_found;

    // unpack input fields, position in the low bits
    assign in_position = s_tdata[ADDR_W-1:0];
    assign in_value    = s_tdata[ADDR_W +: DATA_W];

    // sequencer: one transfer accepted in idle; a search then runs the probe/compare loop
    stbs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_mode   (s_tuser),
        .in_ready  (s_tready),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .stat      (stat),
        .cmd       (cmd)
    );

    // table memory, bounds, compare, result register
    stbs_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_position  (in_position),
        .in_value     (in_value),
        .cmd          (cmd),
        .stat         (stat),
        .out_found    (out_found),
        .out_position (out_position)
    );

    // pack result, zero padded to whole bytes
    assign m_tdata = {{(M_TDATA_W-ADDR_W){1'b0}}, out_position};
    assign m_tuser = out_found;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // a table read is only issued while the bounds still enclose a position
    a_rd_in_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd |-> stat.active)
        else $error("table read issued with empty search range");

    // once a search starts, input is held off until its result is published
    a_busy_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> !s_tready)
        else $error("input accepted during a search");

    // publishing a result always presents it on the output
    a_publish_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |=> m_tvalid)
        else $error("published result not presented");

    // a miss reports position zero
    a_miss_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[ADDR_W-1:0] == '0))
        else $error("not-found result with nonzero position");

endmodule

// ===== sim/tb_top.sv =====
// ============================================================================
// tb_top
// Self-checking bench for sorted_table_binary_search. A directed table covers
// reset count, empty table, field extremes and an out-of-order table. Random
// phases then load sorted (sometimes shuffled) tables, change element_count
// and search. Every search result is compared with a typed answer or an in-bench
// bisection model, under random source gaps and sink backpressure.
// ============================================================================
module tb_top;
    import stbs_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 32;        // outlasts the longest search
    localparam int ITEM_TARGET   = 1450;
    localparam int RUN_LIMIT     = 4_000_000; // hang guard limit
    localparam int DIRECTED_ROWS = 22;

    // one search answer, as carried by m_tuser / m_tdata
    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_position;
    } lookup_result_t;

    typedef enum logic [1:0] {ROW_CONFIG, ROW_WRITE, ROW_SEARCH} row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [ADDR_W-1:0] position;
        logic [DATA_W-1:0] value;   // element, target, or element_count
        logic              typed;   // answer spelled out in the row
        lookup_result_t    result;
    } directed_row_t;

    // ------------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [COUNT_W-1:0]    cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata     = '0;  // [9:0] position, [41:10] value, pad
    logic                  s_tuser     = 1'b0; // [0] mode
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;           // [9:0] match_position, pad
    logic                  m_tuser;           // [0] found

    sorted_table_binary_search dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Bench-side copy of the block state
    // ------------------------------------------------------------------------
    logic signed [DATA_W-1:0] element_model [TABLE_DEPTH];
    logic [COUNT_W-1:0]       element_count_model = COUNT_W'(1);  // reset value
    lookup_result_t           pending_lookups [$];       // oldest first
    int                       fail_count     = 0;
    int                       items_accepted = 0;
    int                       tx_idle_pct    = 0;
    int                       rx_stall_pct   = 0;

    // Directed rows. Typed answers only where they are obvious; the rest go
    // through the bisection model.
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        // reset count is 1: only entry 0 is searched
        '{ROW_WRITE,  10'd0,    32'h8000_0000, 1'b0, '{1'b0, 10'd0}},
        '{ROW_SEARCH, 10'h3FF,  32'h8000_0000, 1'b1, '{1'b1, 10'd0}},
        '{ROW_SEARCH, 10'd0,    32'h0000_0000, 1'b1, '{1'b0, 10'd0}},
        // empty table: nothing probed, always a miss
        '{ROW_CONFIG, 10'd0,    32'd0,         1'b0, '{1'b0, 10'd0}},
        '{ROW_SEARCH, 10'h155,  32'h7FFF_FFFF, 1'b1, '{1'b0, 10'd0}},
        '{ROW_SEARCH, 10'h2AA,  32'h8000_0000, 1'b1, '{1'b0, 10'd0}},
        // five sorted entries spanning the signed range
        '{ROW_WRITE,  10'd1,    32'hFFFF_FFFB, 1'b0, '{1'b0, 10'd0}},
        '{ROW_WRITE,  10'd2,    32'h0000_0000, 1'b0, '{1'b0, 10'd0}},
        '{ROW_WRITE,  10'd3,    32'h0000_0007, 1'b0, '{1'b0, 10'd0}},
        '{ROW_WRITE,  10'd4,    32'h7FFF_FFFF, 1'b0, '{1'b0, 10'd0}},
        '{ROW_WRITE,  10'h3FF,  32'h5555_5555, 1'b0, '{1'b0, 10'd0}},
        '{ROW_CONFIG, 10'd0,    32'd5,         1'b0, '{1'b0, 10'd0}},
        '{ROW_SEARCH, 10'd0,    32'h7FFF_FFFF, 1'b1, '{1'b1, 10'd4}},
        '{ROW_SEARCH, 10'h3FF,  32'h0000_0007, 1'b0, '{1'b0, 10'd0}},
        '{ROW_SEARCH, 10'd17,   32'h0000_0006, 1'b0, '{1'b0, 10'd0}},
        '{ROW_SEARCH, 10'd511,  32'hFFFF_FFFB, 1'b0, '{1'b0, 10'd0}},
        '{ROW_SEARCH, 10'd512,  32'h8000_0000, 1'b0, '{1'b0, 10'd0}},
        // break the order: probes follow the bisection anyway
        '{ROW_WRITE,  10'd2,    32'h0000_0064, 1'b0, '{1'b0, 10'd0}},
        '{ROW_SEARCH, 10'd3,    32'h0000_0007, 1'b0, '{1'b0, 10'd0}},
        '{ROW_CONFIG, 10'd0,    32'd3,         1'b0, '{1'b0, 10'd0}},
        '{ROW_SEARCH, 10'd0,    32'h0000_0064, 1'b0, '{1'b0, 10'd0}},
        '{ROW_SEARCH, 10'h3FF,  32'hAAAA_AAAA, 1'b0, '{1'b0, 10'd0}}
    };

    // Bisection over positions 0..count-1, count saturated at table depth.
    function automatic lookup_result_t bisect_lookup(logic signed [DATA_W-1:0] target);
        lookup_result_t r;
        int             span;
        int             lo;
        int             hi;
        int             mid;
        r    = '0;
        span = (element_count_model > TABLE_DEPTH) ? TABLE_DEPTH
                                                   : int'(element_count_model);
        lo   = 0;
        hi   = span - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (element_model[mid] == target) begin
                r.found          = 1'b1;
                r.match_position = ADDR_W'(mid);
                break;
            end else if (element_model[mid] > target) begin
                hi = mid - 1;
            end else begin
                lo = mid + 1;
            end
        end
        return r;
    endfunction

    // One input transfer: optional source gap, hold until accepted, then
    // update the model (writes) or queue the expected answer (searches).
    task automatic transfer_item(input logic              mode,
                                 input logic [ADDR_W-1:0] position,
                                 input logic [DATA_W-1:0] value,
                                 input logic              typed = 1'b0,
                                 input lookup_result_t    typed_result = '0);
        while ($urandom_range(1, 100) <= tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(S_TDATA_W - ADDR_W - DATA_W){1'b0}}, value, position};
        do @(posedge aclk); while (!s_tready);
        items_accepted++;
        if (mode == MODE_WRITE)
            element_model[position] = value;
        else if (typed)
            pending_lookups.push_back(typed_result);
        else
            pending_lookups.push_back(bisect_lookup(value));
    endtask

    // Wait for every pending answer, then let a trailing write retire.
    task automatic drain_lookups();
        s_tvalid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // element_count is only changed while the block is idle
    task automatic write_count(input logic [COUNT_W-1:0] count);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        element_count_model = count;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random backpressure, compare each transfer in order
    // ------------------------------------------------------------------------
    initial begin : result_check
        lookup_result_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (pending_lookups.size() == 0) begin
                    $error("unexpected result: found=%0d match_position=%0d",
                           m_tuser, m_tdata[ADDR_W-1:0]);
                    fail_count++;
                end else begin
                    want = pending_lookups.pop_front();
                    if (m_tuser !== want.found) begin
                        $error("found: expected %0d, actual %0d", want.found, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[ADDR_W-1:0] !== want.match_position) begin
                        $error("match_position: expected %0d, actual %0d",
                               want.match_position, m_tdata[ADDR_W-1:0]);
                        fail_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(1, 100) > rx_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        directed_row_t      row;
        int                 phase;
        int                 live;
        int                 n_lookups;
        int                 pick;
        int                 r;
        logic [COUNT_W-1:0] count;
        logic [DATA_W-1:0]  target;
        logic               shuffled;
        logic               narrow;
        int                 fill_values [$];

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            case (row.kind)
                ROW_CONFIG: begin
                    drain_lookups();
                    write_count(row.value[COUNT_W-1:0]);
                end
                ROW_WRITE:  transfer_item(MODE_WRITE, row.position, row.value);
                default:    transfer_item(MODE_SEARCH, row.position, row.value,
                                          row.typed, row.result);
            endcase
        end

        // Random phases. Phase 3 loads the whole table; phases 4 and 5 reuse
        // it with counts above the depth (saturation). The rest are small.
        phase = 0;
        while (phase < 6 || items_accepted < ITEM_TARGET) begin
            drain_lookups();
            case (phase % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 51; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 51; end
                default: begin tx_idle_pct = 35; rx_stall_pct = 35; end
            endcase

            if (phase == 3)
                count = COUNT_W'(TABLE_DEPTH);
            else if (phase == 4)
                count = '1;
            else if (phase == 5)
                count = COUNT_W'($urandom_range(TABLE_DEPTH + 1, 2046));
            else if ($urandom_range(0, 9) == 0)
                count = '0;
            else if ($urandom_range(0, 4) == 0)
                count = COUNT_W'($urandom_range(41, 160));
            else
                count = COUNT_W'($urandom_range(1, 40));
            write_count(count);
            live = (count > TABLE_DEPTH) ? TABLE_DEPTH : int'(count);

            // reload positions 0..live-1 (phases 4 and 5 keep the full table)
            if (phase != 4 && phase != 5) begin
                shuffled = (phase > 5) && ($urandom_range(0, 5) == 0);
                narrow   = 1'($urandom_range(0, 1));  // narrow range: duplicates
                fill_values.delete();
                for (int i = 0; i < live; i++)
                    fill_values.push_back(narrow ? int'($urandom_range(0, 2 * live)) - live
                                                 : int'($urandom));
                if (!shuffled && live > 0) begin
                    fill_values.sort();
                    if ($urandom_range(0, 3) == 0) fill_values[0] = int'(32'h8000_0000);
                    if ($urandom_range(0, 3) == 0) fill_values[live-1] = int'(32'h7FFF_FFFF);
                end
                for (int i = 0; i < live; i++)
                    transfer_item(MODE_WRITE, ADDR_W'(i), fill_values[i]);
            end

            n_lookups = (phase == 3) ? 60 : $urandom_range(10, 40);
            for (int k = 0; k < n_lookups; k++) begin
                r    = $urandom_range(0, 9);
                pick = (live > 0) ? $urandom_range(0, live - 1) : 0;
                if (r == 0) begin
                    // stray write: inside the live range it rewrites the same
                    // element so the order holds
                    pick = $urandom_range(0, TABLE_DEPTH - 1);
                    transfer_item(MODE_WRITE, ADDR_W'(pick),
                                  (pick < live) ? element_model[pick] : $urandom);
                end else begin
                    if (live == 0 || r >= 8)
                        target = (r == 9) ? ($urandom_range(0, 1) ? 32'h7FFF_FFFF
                                                                  : 32'h8000_0000)
                                          : $urandom;
                    else if (r <= 4)
                        target = element_model[pick];           // hit
                    else if (r == 5)
                        target = element_model[pick] + 32'd1;   // near miss above
                    else
                        target = element_model[pick] - 32'd1;   // near miss below
                    transfer_item(MODE_SEARCH, ADDR_W'($urandom_range(0, TABLE_DEPTH - 1)),
                                  target);
                end
            end
            phase++;
        end

        drain_lookups();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // hang guard
    initial begin
        #RUN_LIMIT;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/stbs_pkg.sv
rtl/stbs_ctrl.sv
rtl/stbs_dp.sv
rtl/sorted_table_binary_search.sv
sim/tb_top.sv
